// ----- rtl/hermite_spline_table_eval_assert.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the spline table block
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef HERMITE_SPLINE_TABLE_EVAL_ASSERT_SVH
`define HERMITE_SPLINE_TABLE_EVAL_ASSERT_SVH

// same-cycle implication
`define HSTE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hste_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hste_pkg
// shared types and constants of the spline table evaluator
// ----------------------------------------------------------------------------
package hste_pkg;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_EVAL   = 1'b1;

	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [31:0] val;
		logic signed [31:0] tan_in;
		logic signed [31:0] tan_out;
	} knot_t;

	// broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic               rep;
		logic signed [31:0] x;
		knot_t              knot;
	} cell_cmd_t;

	// segment handed to the evaluator
	typedef struct packed {
		logic               interior;
		logic signed [31:0] spec_value;
		knot_t              left;
		knot_t              right;
		logic signed [31:0] s;
	} eval_sel_t;

	typedef enum logic [3:0] {
		EV_IDLE,
		EV_DIV,
		EV_MA,
		EV_MB,
		EV_MC,
		EV_MD,
		EV_ME,
		EV_MF,
		EV_MG,
		EV_MH,
		EV_MI,
		EV_MJ,
		EV_DONE
	} eval_state_t;

endpackage

// ----- rtl/hste_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hste_req_if
// input channel: insert or evaluate request
// ----------------------------------------------------------------------------
interface hste_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] knot_x;
	logic signed [31:0] knot_y;
	logic signed [31:0] slope_in;
	logic signed [31:0] slope_out;
	logic signed [31:0] query_s;

	modport source (output valid, func, knot_x, knot_y, slope_in, slope_out, query_s,
		input ready);
	modport sink (input valid, func, knot_x, knot_y, slope_in, slope_out, query_s,
		output ready);
endinterface

// ----- rtl/hste_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hste_rsp_if
// output channel: one result per request
// ----------------------------------------------------------------------------
interface hste_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               replaced;
	logic               dropped;

	modport source (output valid, value, replaced, dropped, input ready);
	modport sink (input valid, value, replaced, dropped, output ready);
endinterface

// ----- rtl/hste_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hste_cell
// one knot slot of the sorted chain; shifts right from its neighbor on insert
// ----------------------------------------------------------------------------
module hste_cell (
	input  logic               clk,
	input  hste_pkg::cell_cmd_t cmd,
	input  logic signed [31:0] query,
	input  logic               valid,
	input  logic               prev_valid,
	input  logic               prev_gt,
	input  logic               prev_le,
	input  hste_pkg::knot_t    prev_knot,
	input  logic               next_le,
	output hste_pkg::knot_t    knot,
	output logic               gt,
	output logic               le,
	output logic               eq,
	output logic               is_left,
	output logic               is_right,
	output hste_pkg::knot_t    left,
	output hste_pkg::knot_t    right
);
	import hste_pkg::*;

	knot_t knot_q;
	logic  take_prev;
	logic  take_new;

	assign knot = knot_q;
	assign gt   = valid && (knot_q.pos > cmd.x);
	assign eq   = valid && (knot_q.pos == cmd.x);
	assign le   = valid && (knot_q.pos <= query);

	assign take_prev = cmd.ins && prev_gt;
	assign take_new  = cmd.ins && !prev_gt && prev_valid && (gt || !valid);

	assign is_left  = le && !next_le;
	assign is_right = valid && prev_le && !le;
	assign left     = is_left ? knot_q : '0;
	assign right    = is_right ? knot_q : '0;

	always_ff @(posedge clk) begin
		if (take_prev) begin
			knot_q <= prev_knot;
		end else if (take_new) begin
			knot_q <= cmd.knot;
		end else if (cmd.rep && eq) begin
			knot_q.val     <= cmd.knot.val;
			knot_q.tan_in  <= cmd.knot.tan_in;
			knot_q.tan_out <= cmd.knot.tan_out;
		end
	end
endmodule

// ----- rtl/hste_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hste_eval
// segment evaluator: serial divide for t, then a short multiply sequence
// ----------------------------------------------------------------------------
module hste_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  hste_pkg::eval_sel_t sel,
	output logic               idle,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [31:0] res_value
);
	import hste_pkg::*;

	localparam int TBITS = 16;

	eval_state_t state_q, state_d;

	logic signed [31:0] y0_q, y1_q, tout0_q, tin1_q;
	logic        [32:0] dx_q;
	logic        [32:0] rem_q;
	logic [TBITS-1:0]   quo_q;
	logic [3:0]         cnt_q;
	logic signed [64:0] bigp_q;
	logic signed [71:0] prod_q;
	logic signed [49:0] a_q, b_q, acc_q;
	logic signed [33:0] base_q;
	logic signed [52:0] inner_q;
	logic        [16:0] w_q;
	logic signed [31:0] value_q;

	logic        [33:0] sh;
	logic               ge;
	logic        [33:0] sub;
	logic signed [32:0] dy;
	logic        [16:0] u;
	logic signed [31:0] big_a;
	logic signed [53:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [49:0] base_sum;
	logic signed [56:0] fin;

	assign idle      = (state_q == EV_IDLE);
	assign res_valid = (state_q == EV_DONE);
	assign res_value = value_q;

	assign sh  = {rem_q, 1'b0};
	assign ge  = sh >= {1'b0, dx_q};
	assign sub = sh - {1'b0, dx_q};
	assign dy  = {y1_q[31], y1_q} - {y0_q[31], y0_q};
	assign u   = 17'h10000 - {1'b0, quo_q};
	assign base_sum = acc_q + prod_q[49:0];
	assign fin = 57'(base_q) + 57'($signed(prod_q[71:16]));

	assign big_a = (state_q == EV_MA) ? tout0_q : tin1_q;

	// operand select of the shared narrow multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			EV_MC: begin
				mul_a = 54'(y0_q);
				mul_b = {1'b0, u};
			end
			EV_MD: begin
				mul_a = 54'(y1_q);
				mul_b = {2'b00, quo_q};
			end
			EV_ME: begin
				mul_a = 54'(a_q);
				mul_b = {1'b0, u};
			end
			EV_MF: begin
				mul_a = 54'(b_q);
				mul_b = {2'b00, quo_q};
			end
			EV_MG: begin
				mul_a = {38'd0, quo_q};
				mul_b = {1'b0, u};
			end
			EV_MI: begin
				mul_a = 54'(inner_q);
				mul_b = {1'b0, w_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			EV_IDLE: if (start) state_d = sel.interior ? EV_DIV : EV_DONE;
			EV_DIV:  if (cnt_q == 4'(TBITS - 1)) state_d = EV_MA;
			EV_MA:   state_d = EV_MB;
			EV_MB:   state_d = EV_MC;
			EV_MC:   state_d = EV_MD;
			EV_MD:   state_d = EV_ME;
			EV_ME:   state_d = EV_MF;
			EV_MF:   state_d = EV_MG;
			EV_MG:   state_d = EV_MH;
			EV_MH:   state_d = EV_MI;
			EV_MI:   state_d = EV_MJ;
			EV_MJ:   state_d = EV_DONE;
			EV_DONE: if (res_ready) state_d = EV_IDLE;
			default: state_d = EV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		bigp_q <= big_a * $signed(dx_q);
		case (state_q)
			EV_IDLE: begin
				if (start) begin
					y0_q    <= sel.left.val;
					tout0_q <= sel.left.tan_out;
					y1_q    <= sel.right.val;
					tin1_q  <= sel.right.tan_in;
					dx_q    <= 33'({sel.right.pos[31], sel.right.pos}
						- {sel.left.pos[31], sel.left.pos});
					rem_q   <= 33'({sel.s[31], sel.s} - {sel.left.pos[31], sel.left.pos});
					quo_q   <= '0;
					cnt_q   <= '0;
					value_q <= sel.spec_value;
				end
			end
			EV_DIV: begin
				rem_q <= ge ? sub[32:0] : sh[32:0];
				quo_q <= {quo_q[TBITS-2:0], ge};
				cnt_q <= cnt_q + 4'd1;
			end
			EV_MB: a_q <= 50'($signed(bigp_q[64:16])) - 50'(dy);
			EV_MC: b_q <= 50'(dy) - 50'($signed(bigp_q[64:16]));
			EV_MD: acc_q <= prod_q[49:0];
			EV_ME: base_q <= base_sum[49:16];
			EV_MF: inner_q <= prod_q[68:16];
			EV_MG: inner_q <= inner_q + prod_q[68:16];
			EV_MH: w_q <= prod_q[32:16];
			EV_MJ: begin
				if (fin > 57'sd2147483647) begin
					value_q <= 32'sh7fffffff;
				end else if (fin < -57'sd2147483648) begin
					value_q <= 32'sh80000000;
				end else begin
					value_q <= fin[31:0];
				end
			end
			default: ;
		endcase
	end
endmodule

// ----- rtl/hermite_spline_table_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_spline_table_eval
// sorted knot table with cubic hermite evaluation
// ----------------------------------------------------------------------------
// Knots live in a chain of MAX_KNOTS cells kept sorted by position. An insert
// finishes in the cycle it is accepted: every cell compares its position with
// knot_x and either keeps its knot, takes its left neighbor's knot or takes
// the new one; on a replace the matching cell takes the new value and
// tangents. An insert transfer is followed by its result in the next cycle.
// An evaluate first locates the segment across the chain, then runs a
// bit-serial divider for t and then the multiply sequence; a query outside
// the knot interior skips both. The block takes one request at a time;
// a finished result waits in the output register, and no new request is
// taken until that result transfers or transfers in the same cycle.
module hermite_spline_table_eval #(
	parameter int MAX_KNOTS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	hste_req_if.sink   req,
	hste_rsp_if.source rsp
);
	import hste_pkg::*;

	localparam int CW = $clog2(MAX_KNOTS + 1);

	// table fill and evaluation handoff
	logic [CW-1:0]      count_q;
	logic signed [31:0] query_q;
	logic               start_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic               out_rep_q;
	logic               out_drop_q;

	// chain wiring
	knot_t                c_knot  [MAX_KNOTS];
	knot_t                c_left  [MAX_KNOTS];
	knot_t                c_right [MAX_KNOTS];
	logic [MAX_KNOTS-1:0] c_valid, c_gt, c_le, c_eq, c_isl, c_isr;

	cell_cmd_t cmd;
	eval_sel_t sel;
	knot_t     left_or, right_or;
	logic      out_free, acc, acc_ins, acc_eval, eq_any, full;
	logic      ev_idle, ev_valid;
	logic signed [31:0] ev_value;

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = ev_idle && !start_q && out_free;
	assign acc      = req.valid && req.ready;
	assign acc_ins  = acc && (req.func == FUNC_INSERT);
	assign acc_eval = acc && (req.func == FUNC_EVAL);

	assign eq_any = |c_eq;
	assign full   = (count_q == CW'(MAX_KNOTS));

	// broadcast for the cells; replace wins over full
	assign cmd.ins  = acc_ins && !eq_any && !full;
	assign cmd.rep  = acc_ins && eq_any;
	assign cmd.x    = req.knot_x;
	assign cmd.knot = '{pos: req.knot_x, val: req.knot_y,
		tan_in: req.slope_in, tan_out: req.slope_out};

	for (genvar i = 0; i < MAX_KNOTS; i++) begin : g_cell
		assign c_valid[i] = (CW'(i) < count_q);
		if (i == 0) begin : g_first
			hste_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.query      (query_q),
				.valid      (c_valid[i]),
				.prev_valid (1'b1),
				.prev_gt    (1'b0),
				.prev_le    (1'b0),
				.prev_knot  ('0),
				.next_le    ((i + 1 < MAX_KNOTS) ? c_le[(i + 1) % MAX_KNOTS] : 1'b0),
				.knot       (c_knot[i]),
				.gt         (c_gt[i]),
				.le         (c_le[i]),
				.eq         (c_eq[i]),
				.is_left    (c_isl[i]),
				.is_right   (c_isr[i]),
				.left       (c_left[i]),
				.right      (c_right[i])
			);
		end else begin : g_rest
			hste_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.query      (query_q),
				.valid      (c_valid[i]),
				.prev_valid (c_valid[i-1]),
				.prev_gt    (c_gt[i-1]),
				.prev_le    (c_le[i-1]),
				.prev_knot  (c_knot[i-1]),
				.next_le    ((i + 1 < MAX_KNOTS) ? c_le[(i + 1) % MAX_KNOTS] : 1'b0),
				.knot       (c_knot[i]),
				.gt         (c_gt[i]),
				.le         (c_le[i]),
				.eq         (c_eq[i]),
				.is_left    (c_isl[i]),
				.is_right   (c_isr[i]),
				.left       (c_left[i]),
				.right      (c_right[i])
			);
		end
	end

	// at most one cell flags each side, so an or picks it out
	always_comb begin
		left_or  = '0;
		right_or = '0;
		for (int i = 0; i < MAX_KNOTS; i++) begin
			left_or  = left_or | c_left[i];
			right_or = right_or | c_right[i];
		end
	end

	// edge cases: empty table, query below first knot, at or past last knot
	always_comb begin
		sel.interior = (|c_isl) && (|c_isr);
		sel.left     = left_or;
		sel.right    = right_or;
		sel.s        = query_q;
		if (count_q == '0) begin
			sel.spec_value = '0;
		end else if (!(|c_isl)) begin
			sel.spec_value = c_knot[0].val;
		end else begin
			sel.spec_value = left_or.val;
		end
	end

	hste_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.sel       (sel),
		.idle      (ev_idle),
		.res_valid (ev_valid),
		.res_ready (out_free),
		.res_value (ev_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= acc_eval;
			if (cmd.ins) begin
				count_q <= count_q + CW'(1);
			end
			if (acc_ins || (ev_valid && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the output register and the query
	always_ff @(posedge clk) begin
		if (acc_eval) begin
			query_q <= req.query_s;
		end
		if (acc_ins) begin
			out_value_q <= '0;
			out_rep_q   <= eq_any;
			out_drop_q  <= !eq_any && full;
		end else if (ev_valid && out_free) begin
			out_value_q <= ev_value;
			out_rep_q   <= 1'b0;
			out_drop_q  <= 1'b0;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.value    = out_value_q;
	assign rsp.replaced = out_rep_q;
	assign rsp.dropped  = out_drop_q;

`include "hermite_spline_table_eval_assert.svh"

	`HSTE_ASSERT_SAME(a_rep_drop_excl, rsp.valid, !(rsp.replaced && rsp.dropped), "replaced and dropped together")
	`HSTE_ASSERT_SAME(a_count_range, 1'b1, count_q <= CW'(MAX_KNOTS), "knot count above capacity")
	`HSTE_ASSERT_SAME(a_busy_blocks, !ev_idle || start_q, !req.ready, "request taken while evaluating")
	`HSTE_ASSERT_NEXT(a_count_grow, cmd.ins, count_q == $past(count_q) + CW'(1), "count did not grow on insert")
	`HSTE_ASSERT_SAME(a_one_left, start_q, $onehot0(c_isl), "more than one left knot selected")
endmodule

// ----- tb/hermite_spline_table_eval_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_spline_table_eval_tb
// self-checking bench for the sorted knot table and spline evaluator
// ----------------------------------------------------------------------------
// Requests are sent through the request channel with random gaps. A shadow
// knot table, updated on each accepted request transfer, works out the
// expected result. Each response transfer is compared field by field with
// the oldest pending result. Directed tests cover the empty table, ordered
// insertion, replacement, the ends of the table, saturation and a full
// table; a long random test follows.
// ----------------------------------------------------------------------------
module hermite_spline_table_eval_tb;
	import hste_pkg::*;

	localparam int  KNOT_DEPTH  = 16;
	localparam int  RANDOM_REQS = 1320;
	localparam int  CYCLE_LIMIT = 600000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;
	localparam logic signed [31:0] Q_ONE = 32'sh00010000;

	typedef struct {
		logic signed [31:0] value;
		logic               replaced;
		logic               dropped;
	} spline_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   cycles = 0;
	int   fails = 0;
	int   n_eval = 0;
	int   n_rep = 0;
	int   n_drop = 0;
	int   n_sat = 0;

	// shadow copy of the knot table
	logic signed [31:0] shadow_pos[KNOT_DEPTH];
	logic signed [31:0] shadow_val[KNOT_DEPTH];
	logic signed [31:0] shadow_tin[KNOT_DEPTH];
	logic signed [31:0] shadow_tout[KNOT_DEPTH];
	int                 shadow_count = 0;

	spline_result_t pending_results[$];

	hste_req_if req_ch();
	hste_rsp_if rsp_ch();

	hermite_spline_table_eval #(.MAX_KNOTS(KNOT_DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// floor(v * q / 2^16) without overflowing the product
	function automatic longint scale_q16(longint v, longint q);
		longint hi;
		longint lo;
		hi = v >>> 16;
		lo = v - hi * 65536;
		return hi * q + ((lo * q) >>> 16);
	endfunction

	// hermite value on the segment whose right knot is r
	function automatic longint segment_value(int r, longint s);
		longint x0, x1, y0, y1, tout0, tin1;
		longint dx, ds, t, u, dy, a, b, base, inner, w;
		x0 = shadow_pos[r-1];
		x1 = shadow_pos[r];
		y0 = shadow_val[r-1];
		y1 = shadow_val[r];
		tout0 = shadow_tout[r-1];
		tin1 = shadow_tin[r];
		dx = x1 - x0;
		ds = s - x0;
		t = 0;
		// both are below 2^33 here, so the shifted quotient stays positive
		if (dx > 0 && ds >= 0) begin
			t = (ds << 16) / dx;
		end
		if (t > 65535) begin
			t = 65535;
		end
		u = 65536 - t;
		dy = y1 - y0;
		a = ((tout0 * dx) >>> 16) - dy;
		b = dy - ((tin1 * dx) >>> 16);
		base = (u * y0 + t * y1) >>> 16;
		inner = scale_q16(a, u) + scale_q16(b, t);
		w = (t * u) >>> 16;
		return base + scale_q16(inner, w);
	endfunction

	// apply one accepted request to the shadow table, queue its result
	task automatic apply_request(logic f, logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] si, logic signed [31:0] so, logic signed [31:0] q);
		spline_result_t r;
		int i;
		longint v;
		r = '{value: '0, replaced: 1'b0, dropped: 1'b0};
		if (f == FUNC_INSERT) begin
			i = 0;
			while (i < shadow_count && shadow_pos[i] < x) begin
				i++;
			end
			if (i < shadow_count && shadow_pos[i] == x) begin
				shadow_val[i] = y;
				shadow_tin[i] = si;
				shadow_tout[i] = so;
				r.replaced = 1'b1;
				n_rep++;
			end else if (shadow_count >= KNOT_DEPTH) begin
				r.dropped = 1'b1;
				n_drop++;
			end else begin
				for (int j = shadow_count; j > i; j--) begin
					shadow_pos[j] = shadow_pos[j-1];
					shadow_val[j] = shadow_val[j-1];
					shadow_tin[j] = shadow_tin[j-1];
					shadow_tout[j] = shadow_tout[j-1];
				end
				shadow_pos[i] = x;
				shadow_val[i] = y;
				shadow_tin[i] = si;
				shadow_tout[i] = so;
				shadow_count++;
			end
		end else begin
			n_eval++;
			i = 0;
			while (i < shadow_count && shadow_pos[i] <= q) begin
				i++;
			end
			if (shadow_count == 0) begin
				v = 0;
			end else if (i == 0) begin
				v = shadow_val[0];
			end else if (i >= shadow_count) begin
				v = shadow_val[shadow_count-1];
			end else begin
				v = segment_value(i, q);
			end
			if (v > longint'(Q_MAX)) begin
				v = Q_MAX;
				n_sat++;
			end else if (v < longint'(Q_MIN)) begin
				v = Q_MIN;
				n_sat++;
			end
			r.value = v[31:0];
		end
		pending_results.push_back(r);
	endtask

	// request side: predict on every transfer
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			apply_request(req_ch.func, req_ch.knot_x, req_ch.knot_y, req_ch.slope_in,
				req_ch.slope_out, req_ch.query_s);
		end
	end

	// response side: random backpressure and checking
	always @(posedge clk) begin
		spline_result_t exp_r;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(99) >= 20);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("response transfer with no result pending");
					fails++;
				end else begin
					exp_r = pending_results.pop_front();
					if (rsp_ch.value !== exp_r.value) begin
						$error("value expected %0d got %0d", exp_r.value, rsp_ch.value);
						fails++;
					end
					if (rsp_ch.replaced !== exp_r.replaced) begin
						$error("replaced expected %0b got %0b", exp_r.replaced,
							rsp_ch.replaced);
						fails++;
					end
					if (rsp_ch.dropped !== exp_r.dropped) begin
						$error("dropped expected %0b got %0b", exp_r.dropped,
							rsp_ch.dropped);
						fails++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL hermite_spline_table_eval");
			$finish;
		end
	end

	// valid stays high from one request to the next unless a gap falls between
	task automatic send_request(logic f, logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] si, logic signed [31:0] so, logic signed [31:0] q);
		while (!calm && $urandom_range(99) < 20) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.knot_x <= x;
		req_ch.knot_y <= y;
		req_ch.slope_in <= si;
		req_ch.slope_out <= so;
		req_ch.query_s <= q;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
	endtask

	task automatic send_insert(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] si, logic signed [31:0] so);
		send_request(FUNC_INSERT, x, y, si, so, $urandom());
	endtask

	task automatic send_eval(logic signed [31:0] q);
		send_request(FUNC_EVAL, $urandom(), $urandom(), $urandom(), $urandom(), q);
	endtask

	// a mix of full-range, moderate and extreme values
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $signed($urandom_range(32'h00800000)) - 32'sh00400000;
			2: return $urandom_range(1) ? Q_MAX : Q_MIN;
			default: return $signed($urandom_range(32'h00080000)) - 32'sh00040000;
		endcase
	endfunction

	task automatic test_empty_table();
		send_eval(32'sh0);
		send_eval(Q_MIN);
		send_eval(Q_MAX);
	endtask

	task automatic test_ordered_insert();
		// out of order, so the chain has to shift
		send_insert(3 * Q_ONE, 32'sh00030000, Q_ONE, -Q_ONE);
		send_insert(1 * Q_ONE, -32'sh00020000, 32'sh00008000, 32'sh00020000);
		send_insert(2 * Q_ONE, 32'sh00010000, 32'sh0, 32'sh0);
		send_insert(2 * Q_ONE, 32'sh00050000, -Q_ONE, Q_ONE);
		send_eval(32'sh0);
		send_eval(1 * Q_ONE);
		send_eval(32'sh00018000);
		send_eval(32'sh00024000);
		send_eval(3 * Q_ONE);
		send_eval(Q_MAX);
	endtask

	task automatic test_saturation();
		send_insert(4 * Q_ONE, Q_MAX, Q_MAX, Q_MAX);
		send_insert(32'sh7fff0000, Q_MAX, Q_MIN, Q_MIN);
		send_eval(32'sh00038000);
		send_eval(32'sh40000000);
		send_insert(5 * Q_ONE, Q_MIN, Q_MIN, Q_MAX);
		send_eval(32'sh00048000);
		send_eval(32'sh20000000);
	endtask

	task automatic test_full_table();
		send_insert(Q_MIN, pick_value(), pick_value(), pick_value());
		send_insert(Q_MAX, pick_value(), pick_value(), pick_value());
		// a late count only adds an insert that comes back dropped
		while (shadow_count < KNOT_DEPTH) begin
			send_insert($urandom(), pick_value(), pick_value(), pick_value());
		end
		send_insert(32'sh00028000, pick_value(), pick_value(), pick_value());
		send_insert(32'sh00000001, pick_value(), pick_value(), pick_value());
		send_insert(Q_MAX, 32'sh00123456, Q_ONE, -Q_ONE);
		send_eval(Q_MIN);
		send_eval(Q_MAX);
		send_eval(32'sh7ffffffe);
	endtask

	task automatic test_random_traffic();
		int k;
		longint lo;
		longint span;
		logic signed [31:0] q;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			calm = (n >= 400 && n < 700);
			k = $urandom_range(shadow_count - 1);
			if ($urandom_range(99) < 50) begin
				case ($urandom_range(9))
					0, 1: q = $urandom();
					2, 3, 4: q = shadow_pos[k] + $signed($urandom_range(8)) - 4;
					default: begin
						// somewhere inside a segment
						if (k == shadow_count - 1) begin
							k--;
						end
						lo = shadow_pos[k];
						span = longint'(shadow_pos[k+1]) - lo;
						q = lo + longint'($urandom()) % span;
					end
				endcase
				send_eval(q);
			end else if ($urandom_range(99) < 75) begin
				send_insert(shadow_pos[k], pick_value(), pick_value(), pick_value());
			end else begin
				send_insert($urandom(), pick_value(), pick_value(), pick_value());
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_INSERT;
		req_ch.knot_x = '0;
		req_ch.knot_y = '0;
		req_ch.slope_in = '0;
		req_ch.slope_out = '0;
		req_ch.query_s = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_ordered_insert();
		test_saturation();
		test_full_table();
		test_random_traffic();

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);

		$display("covered %0d evaluations (%0d saturated), %0d replacements, %0d drops",
			n_eval, n_sat, n_rep, n_drop);
		$display("table held %0d knots at the end, %0d cycles used", shadow_count, cycles);
		if (fails == 0) begin
			$display("PASS hermite_spline_table_eval");
		end else begin
			$display("FAIL hermite_spline_table_eval");
		end
		$finish;
	end

endmodule
